// File: rtl/tmsr_pkg.sv
`default_nettype none

package tmsr_pkg;

   // item kinds carried in req_tuser
   typedef enum logic [1:0] {
      ACT_WRITE_CELL    = 2'd0,
      ACT_WRITE_FONT    = 2'd1,
      ACT_WRITE_PALETTE = 2'd2,
      ACT_RENDER        = 2'd3
   } action_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_COLUMNS_IN_USE     = 2'd0,
      CSR_ROWS_IN_USE        = 2'd1,
      CSR_FONT_SELECT_ENABLE = 2'd2,
      CSR_UNUSED             = 2'd3
   } csr_index_type;

   // render sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CELL,
      ST_PIXEL
   } state_type;

   localparam int unsigned REQ_TDATA_W = 80;
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned CSR_DATA_W  = 8;

   // glyph geometry and font store
   localparam int unsigned CELL_W_BITS = 3;
   localparam int unsigned SCAN_W      = 4;
   localparam int unsigned FONT_AW     = 13;
   localparam int unsigned FONT_DEPTH  = 8192;
   localparam int unsigned PAL_DEPTH   = 16;

   localparam logic [CELL_W_BITS-1:0] LAST_BIT = 3'd7;

   // reset values of the configuration registers
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd25;

endpackage

`default_nettype wire

// File: rtl/tmsr_ram.sv
`default_nettype none

module tmsr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/text_mode_scanline_renderer_core.sv
// Text-mode character generator: 8x16 glyphs, two fonts, 16-color palette.
// req_ channel takes one item per handshake; req_tuser says what it is:
// cell write, font byte write, palette write or render of one scan line
// of one cell. Write items return nothing.
// A render item inside the configured rows and columns returns 8 pixel
// items on the rsp_ channel, leftmost first, rsp_tlast on the eighth.
// A render outside that area returns nothing.
// A render reads the cell when it is accepted, then the font, then loads
// the output register; it occupies the block through the cell read, the
// font read and one pixel per cycle, while the receiver takes them,
// through the single output register. The next item is taken while the
// last pixel still waits in the output register.
// If the receiver stalls, the pixel sequencer holds and no item is taken
// until the last pixel of the run is in the output register.
// csr_ writes set the column and row counts and the font select enable;
// they are taken every cycle and belong to idle periods.
// Reset (synchronous) restores 80 columns, 25 rows, font select off and
// empties the output; text, font and palette contents are kept, and no
// entry may be rendered before it has been written.
`default_nettype none

module text_mode_scanline_renderer_core
   import tmsr_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 128,
   parameter int unsigned MAX_ROWS    = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input items
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // cell_row[5:0], cell_column[12:6], char_code[20:13], cell_attribute[28:21],
   // font_bank[29], scan_line[33:30], glyph_bits[41:34], palette_slot[45:42],
   // palette_color[77:46], zero[79:78]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]             req_tuser,
   // pixel items
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // pixel_x[9:0], pixel_y[19:10], pixel_color[51:20], zero[55:52]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // last_pixel
   output logic                        rsp_tlast,
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned CELL_DEPTH = MAX_ROWS * MAX_COLUMNS;
   localparam int unsigned CELL_AW    = $clog2(CELL_DEPTH);

   // input fields
   logic [5:0]  req_row;
   logic [6:0]  req_col;
   logic [7:0]  req_code;
   logic [7:0]  req_attr;
   logic        req_bank;
   logic [3:0]  req_scan;
   logic [7:0]  req_glyph;
   logic [3:0]  req_slot;
   logic [31:0] req_color;
   action_type  req_action;

   assign req_row    = req_tdata[5:0];
   assign req_col    = req_tdata[12:6];
   assign req_code   = req_tdata[20:13];
   assign req_attr   = req_tdata[28:21];
   assign req_bank   = req_tdata[29];
   assign req_scan   = req_tdata[33:30];
   assign req_glyph  = req_tdata[41:34];
   assign req_slot   = req_tdata[45:42];
   assign req_color  = req_tdata[77:46];
   assign req_action = action_type'(req_tuser);

   // configuration registers
   logic [7:0] columns_ff;
   logic [6:0] rows_ff;
   logic       font_sel_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff     <= COLUMNS_RESET;
         rows_ff        <= ROWS_RESET;
         font_sel_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMNS_IN_USE:     columns_ff     <= csr_data[7:0];
            CSR_ROWS_IN_USE:        rows_ff        <= csr_data[6:0];
            CSR_FONT_SELECT_ENABLE: font_sel_en_ff <= csr_data[0];
            CSR_UNUSED: begin
            end
         endcase
      end
   end

   // address decode of the named cell
   logic              req_accept;
   logic              in_store;
   logic              render_ok;
   logic [31:0]       cell_lin;
   logic [CELL_AW-1:0] cell_addr;

   assign req_accept = req_tvalid && req_tready;
   assign in_store   = (32'(req_row) < 32'(MAX_ROWS)) && (32'(req_col) < 32'(MAX_COLUMNS));
   assign render_ok  = in_store && ({1'b0, req_row} < rows_ff)
                       && ({1'b0, req_col} < columns_ff);
   assign cell_lin   = 32'(req_row) * 32'(MAX_COLUMNS) + 32'(req_col);
   assign cell_addr  = cell_lin[CELL_AW-1:0];

   // sequencer state
   state_type              state_ff, state_in;
   logic [CELL_W_BITS-1:0] bit_ff, bit_in;
   logic [5:0]             row_ff;
   logic [6:0]             col_ff;
   logic [SCAN_W-1:0]      scan_ff;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [9:0]             rsp_x_ff;
   logic [9:0]             rsp_y_ff;
   logic [31:0]            rsp_color_ff;
   logic                   rsp_last_ff;

   // control decode
   logic cell_rd_en;
   logic font_rd_en;
   logic pix_load;
   logic render_start;

   // memories
   logic [15:0]        cell_rd_data;
   logic [7:0]         font_rd_data;
   logic [FONT_AW-1:0] font_wr_addr;
   logic [FONT_AW-1:0] font_rd_addr;
   logic               font_sel;
   logic [31:0]        palette_ff [PAL_DEPTH];

   // text store: {attribute, code} per cell
   tmsr_ram #(
      .WIDTH (16),
      .DEPTH (CELL_DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (req_accept && (req_action == ACT_WRITE_CELL) && in_store),
      .wr_addr (cell_addr),
      .wr_data ({req_attr, req_code}),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_addr),
      .rd_data (cell_rd_data)
   );

   // font store: {bank, code, scan line}
   assign font_wr_addr = {req_bank, req_code, req_scan};
   assign font_sel     = font_sel_en_ff && cell_rd_data[11];
   assign font_rd_addr = {font_sel, cell_rd_data[7:0], scan_ff};

   tmsr_ram #(
      .WIDTH (8),
      .DEPTH (FONT_DEPTH)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (req_accept && (req_action == ACT_WRITE_FONT)),
      .wr_addr (font_wr_addr),
      .wr_data (req_glyph),
      .rd_en   (font_rd_en),
      .rd_addr (font_rd_addr),
      .rd_data (font_rd_data)
   );

   // palette register file
   always_ff @(posedge clock) begin
      if (req_accept && (req_action == ACT_WRITE_PALETTE)) begin
         palette_ff[req_slot] <= req_color;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (render_start) begin
               state_in = ST_CELL;
            end
         end
         ST_CELL: begin
            state_in = ST_PIXEL;
         end
         ST_PIXEL: begin
            if (pix_load && (bit_ff == LAST_BIT)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      font_rd_en = 1'b0;
      pix_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_CELL:  font_rd_en = 1'b1;
         ST_PIXEL: pix_load   = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   assign render_start = req_accept && (req_action == ACT_RENDER) && render_ok;
   assign cell_rd_en   = render_start;

   // pixel counter and output valid
   always_comb begin
      bit_in = bit_ff;
      if (render_start) begin
         bit_in = '0;
      end else if (pix_load) begin
         bit_in = bit_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (pix_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // render coordinates held for the pixel run
   always_ff @(posedge clock) begin
      if (render_start) begin
         row_ff  <= req_row;
         col_ff  <= req_col;
         scan_ff <= req_scan;
      end
   end

   // pixel color: set glyph bit takes foreground, clear bit background
   logic [3:0] pix_nibble;
   logic       glyph_bit;

   assign glyph_bit  = font_rd_data[LAST_BIT - bit_ff];
   assign pix_nibble = glyph_bit ? cell_rd_data[11:8] : cell_rd_data[15:12];

   always_ff @(posedge clock) begin
      if (pix_load) begin
         rsp_x_ff     <= {col_ff, bit_ff};
         rsp_y_ff     <= {row_ff, scan_ff};
         rsp_color_ff <= palette_ff[pix_nibble];
         rsp_last_ff  <= (bit_ff == LAST_BIT);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_color_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/tmsr_checker.sv
`default_nettype none

module tmsr_checker
   import tmsr_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tlast
);

   // a stalled pixel holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled pixel item changed");

   // no pixel can follow an item in the cycle right after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("pixel item appeared too early");

   // no new item is taken while a pixel run is unfinished
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("item taken during a pixel run");

   // the last pixel sits in the rightmost column of its cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[2:0] == LAST_BIT))
      else $error("last pixel flag on wrong column");

endmodule

bind text_mode_scanline_renderer_core tmsr_checker u_tmsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
